// ===== src/tte_pkg.sv =====
// Shared types, constants and register codes of the tick tempo estimator.
package tte_pkg;

    // Field widths
    localparam int TS_W     = 32;
    localparam int GROOVE_W = 5;
    localparam int PPQ_W    = 7;
    localparam int INT_W    = 16;
    localparam int TEMPO_W  = 24;
    localparam int PHASE_W  = 7;

    // Configuration port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int REG_W   = 3;

    localparam logic [REG_W-1:0] REG_GROOVE    = 3'd0;
    localparam logic [REG_W-1:0] REG_PPQ       = 3'd1;
    localparam logic [REG_W-1:0] REG_MIN_INT   = 3'd2;
    localparam logic [REG_W-1:0] REG_MAX_INT   = 3'd3;
    localparam logic [REG_W-1:0] REG_MIN_TEMPO = 3'd4;
    localparam logic [REG_W-1:0] REG_MAX_TEMPO = 3'd5;

    // Reset values of the configuration registers
    localparam logic [GROOVE_W-1:0] RST_GROOVE    = 5'd6;
    localparam logic [PPQ_W-1:0]    RST_PPQ       = 7'd24;
    localparam logic [INT_W-1:0]    RST_MIN_INT   = 16'd5;
    localparam logic [INT_W-1:0]    RST_MAX_INT   = 16'd125;
    localparam logic [TEMPO_W-1:0]  RST_MIN_TEMPO = 24'd5120;
    localparam logic [TEMPO_W-1:0]  RST_MAX_TEMPO = 24'd76800;

    // Iterative divider
    localparam int DVD_W  = 32;
    localparam int DVS_W  = 24;
    localparam int STEP_W = 6;

    // Arithmetic constants
    localparam logic [9:0]         US_PER_MS  = 10'd1000;
    localparam logic [TEMPO_W-1:0] TEMPO_NUM  = 24'd15360000;
    localparam logic [TEMPO_W-1:0] TEMPO_SAT  = 24'hFFFFFF;
    localparam int                 SUM_W      = 23;
    localparam logic [23:0]        RECIP5     = 24'd13421773; // ceil(2^26 / 5)
    localparam int                 RECIP5_SH  = 26;
    localparam int                 PROD_W     = SUM_W + 24;
    localparam int                 AVG_W      = PROD_W - RECIP5_SH;
    localparam int                 DENOM_W    = INT_W + PPQ_W;

    typedef struct packed {
        logic [GROOVE_W-1:0] groove;
        logic [PPQ_W-1:0]    ppq;
        logic [INT_W-1:0]    min_int;
        logic [INT_W-1:0]    max_int;
        logic [TEMPO_W-1:0]  min_tempo;
        logic [TEMPO_W-1:0]  max_tempo;
    } t_cfg;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_DIV_MOD,
        OP_MEASURE,
        OP_DIV_ELAPSED,
        OP_SUM,
        OP_MUL,
        OP_INTERVAL,
        OP_DENOM,
        OP_DIV_TEMPO,
        OP_TEMPO,
        OP_COMMIT,
        OP_OUT
    } t_op;

    typedef struct packed {
        logic div_done;
        logic measure;
        logic have_last;
        logic denom_zero;
        logic out_free;
    } t_status;

endpackage

// ===== src/tte_regs.sv =====
// Configuration register file behind the APB-style port.
module tte_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tte_pkg::PADDR_W-1:0]   paddr,
    input  logic [tte_pkg::PDATA_W-1:0]   pwdata,
    output logic [tte_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output tte_pkg::t_cfg                 o_cfg
);

    tte_pkg::t_cfg              r_cfg;
    logic [tte_pkg::REG_W-1:0]  reg_idx;
    logic                       wr_en;

    assign reg_idx = paddr[tte_pkg::PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.groove    <= tte_pkg::RST_GROOVE;
            r_cfg.ppq       <= tte_pkg::RST_PPQ;
            r_cfg.min_int   <= tte_pkg::RST_MIN_INT;
            r_cfg.max_int   <= tte_pkg::RST_MAX_INT;
            r_cfg.min_tempo <= tte_pkg::RST_MIN_TEMPO;
            r_cfg.max_tempo <= tte_pkg::RST_MAX_TEMPO;
        end else if (wr_en) begin
            unique case (reg_idx)
                tte_pkg::REG_GROOVE:    r_cfg.groove    <= pwdata[tte_pkg::GROOVE_W-1:0];
                tte_pkg::REG_PPQ:       r_cfg.ppq       <= pwdata[tte_pkg::PPQ_W-1:0];
                tte_pkg::REG_MIN_INT:   r_cfg.min_int   <= pwdata[tte_pkg::INT_W-1:0];
                tte_pkg::REG_MAX_INT:   r_cfg.max_int   <= pwdata[tte_pkg::INT_W-1:0];
                tte_pkg::REG_MIN_TEMPO: r_cfg.min_tempo <= pwdata[tte_pkg::TEMPO_W-1:0];
                tte_pkg::REG_MAX_TEMPO: r_cfg.max_tempo <= pwdata[tte_pkg::TEMPO_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            tte_pkg::REG_GROOVE:    prdata = tte_pkg::PDATA_W'(r_cfg.groove);
            tte_pkg::REG_PPQ:       prdata = tte_pkg::PDATA_W'(r_cfg.ppq);
            tte_pkg::REG_MIN_INT:   prdata = tte_pkg::PDATA_W'(r_cfg.min_int);
            tte_pkg::REG_MAX_INT:   prdata = tte_pkg::PDATA_W'(r_cfg.max_int);
            tte_pkg::REG_MIN_TEMPO: prdata = tte_pkg::PDATA_W'(r_cfg.min_tempo);
            tte_pkg::REG_MAX_TEMPO: prdata = tte_pkg::PDATA_W'(r_cfg.max_tempo);
            default:                prdata = '0;
        endcase
    end

endmodule

// ===== src/tte_div.sv =====
// Restoring divider, one quotient bit per cycle.
module tte_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tte_pkg::DVD_W-1:0]     i_dividend,
    input  logic [tte_pkg::DVS_W-1:0]     i_divisor,
    input  logic [tte_pkg::STEP_W-1:0]    i_steps,
    output logic [tte_pkg::DVD_W-1:0]     o_quotient,
    output logic [tte_pkg::DVS_W-1:0]     o_remainder,
    output logic                          o_done
);

    logic [tte_pkg::DVD_W-1:0]   r_quo;
    logic [tte_pkg::DVS_W-1:0]   r_rem;
    logic [tte_pkg::DVS_W-1:0]   r_dvs;
    logic [tte_pkg::STEP_W-1:0]  r_cnt;
    logic                        r_busy;
    logic                        r_done;

    logic [tte_pkg::DVS_W:0]     rem_sh;
    logic [tte_pkg::DVS_W:0]     diff;
    logic                        ge;

    // Shift in the next dividend bit, subtract when it fits
    assign rem_sh = {r_rem, r_quo[tte_pkg::DVD_W-1]};
    assign diff   = rem_sh - {1'b0, r_dvs};
    assign ge     = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
                r_done <= 1'b0;
            end else if (r_busy) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == tte_pkg::STEP_W'(1));
                if (r_cnt == tte_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[tte_pkg::DVD_W-2:0], ge};
            r_rem <= ge ? diff[tte_pkg::DVS_W-1:0] : rem_sh[tte_pkg::DVS_W-1:0];
        end
    end

    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
    assign o_done      = r_done;

endmodule

// ===== src/tte_datapath.sv =====
// Datapath: tick state, smoothing, tempo arithmetic and the result register.
module tte_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tte_pkg::t_op                   i_op,
    input  tte_pkg::t_cfg                  i_cfg,
    input  logic [tte_pkg::TS_W-1:0]       i_timestamp_us,
    input  logic                           i_ready,
    output tte_pkg::t_status               o_status,
    output logic                           o_valid,
    output logic [tte_pkg::INT_W-1:0]      o_interval_ms,
    output logic [tte_pkg::TEMPO_W-1:0]    o_tempo,
    output logic                           o_updated,
    output logic [tte_pkg::PHASE_W-1:0]    o_tick_phase
);

    // Persistent state
    logic [tte_pkg::PHASE_W-1:0]  r_tick;
    logic [tte_pkg::TS_W-1:0]     r_last_time;
    logic                         r_have_last;
    logic [tte_pkg::INT_W-1:0]    r_smoothed;
    logic [tte_pkg::TEMPO_W-1:0]  r_tempo_val;

    // Per-item working registers
    logic [tte_pkg::TS_W-1:0]     r_now;
    logic [tte_pkg::PHASE_W-1:0]  r_phase;
    logic                         r_updated;
    logic                         r_measure;
    logic [tte_pkg::SUM_W-1:0]    r_sum;
    logic [tte_pkg::PROD_W-1:0]   r_prod;
    logic [tte_pkg::DENOM_W-1:0]  r_denom;

    // Result register
    logic                         r_out_valid;
    logic [tte_pkg::INT_W-1:0]    r_out_int;
    logic [tte_pkg::TEMPO_W-1:0]  r_out_tempo;
    logic                         r_out_upd;
    logic [tte_pkg::PHASE_W-1:0]  r_out_phase;

    // Divider hookup
    logic                         div_start;
    logic [tte_pkg::DVD_W-1:0]    div_dvd;
    logic [tte_pkg::DVS_W-1:0]    div_dvs;
    logic [tte_pkg::STEP_W-1:0]   div_steps;
    logic [tte_pkg::DVD_W-1:0]    div_quo;
    logic [tte_pkg::DVS_W-1:0]    div_rem;
    logic                         div_done;

    logic [tte_pkg::GROOVE_W-1:0] groove_eff;
    logic [14:0]                  groove_us;
    logic [tte_pkg::AVG_W-1:0]    avg;
    logic [tte_pkg::INT_W-1:0]    int_clamped;
    logic [tte_pkg::TEMPO_W-1:0]  tempo_raw;
    logic [tte_pkg::TEMPO_W-1:0]  tempo_clamped;
    logic [tte_pkg::PHASE_W-1:0]  tick_inc;
    logic                         out_free;

    assign groove_eff = (i_cfg.groove == '0) ? tte_pkg::GROOVE_W'(1) : i_cfg.groove;
    assign groove_us  = 15'(groove_eff) * 15'(tte_pkg::US_PER_MS);

    assign div_start = (i_op == tte_pkg::OP_DIV_MOD) || (i_op == tte_pkg::OP_DIV_ELAPSED)
                    || (i_op == tte_pkg::OP_DIV_TEMPO);

    // Dividends are left-aligned so that the quotient lands in the low bits
    always_comb begin
        case (i_op)
            tte_pkg::OP_DIV_MOD: begin
                div_dvd   = {r_tick, (tte_pkg::DVD_W - tte_pkg::PHASE_W)'(0)};
                div_dvs   = tte_pkg::DVS_W'(groove_eff);
                div_steps = tte_pkg::STEP_W'(tte_pkg::PHASE_W);
            end
            tte_pkg::OP_DIV_TEMPO: begin
                div_dvd   = {tte_pkg::TEMPO_NUM, (tte_pkg::DVD_W - tte_pkg::TEMPO_W)'(0)};
                div_dvs   = tte_pkg::DVS_W'(r_denom);
                div_steps = tte_pkg::STEP_W'(tte_pkg::TEMPO_W);
            end
            default: begin
                div_dvd   = r_now - r_last_time;
                div_dvs   = tte_pkg::DVS_W'(groove_us);
                div_steps = tte_pkg::STEP_W'(tte_pkg::DVD_W);
            end
        endcase
    end

    tte_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .i_steps    (div_steps),
        .o_quotient (div_quo),
        .o_remainder(div_rem),
        .o_done     (div_done)
    );

    // When the limits cross, values below the lower limit take it and all others take the upper one
    assign avg = r_prod[tte_pkg::PROD_W-1:tte_pkg::RECIP5_SH];
    always_comb begin
        if (avg < tte_pkg::AVG_W'(i_cfg.min_int)) begin
            int_clamped = i_cfg.min_int;
        end else if (avg > tte_pkg::AVG_W'(i_cfg.max_int)) begin
            int_clamped = i_cfg.max_int;
        end else begin
            int_clamped = avg[tte_pkg::INT_W-1:0];
        end
    end

    assign tempo_raw = (r_denom == '0) ? tte_pkg::TEMPO_SAT : div_quo[tte_pkg::TEMPO_W-1:0];
    always_comb begin
        if (tempo_raw < i_cfg.min_tempo) begin
            tempo_clamped = i_cfg.min_tempo;
        end else if (tempo_raw > i_cfg.max_tempo) begin
            tempo_clamped = i_cfg.max_tempo;
        end else begin
            tempo_clamped = tempo_raw;
        end
    end

    assign tick_inc = r_tick + 1'b1;
    assign out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick      <= '0;
            r_last_time <= '0;
            r_have_last <= 1'b0;
            r_smoothed  <= '0;
            r_tempo_val <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_op == tte_pkg::OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_op)
                tte_pkg::OP_INTERVAL: r_smoothed  <= int_clamped;
                tte_pkg::OP_TEMPO:    r_tempo_val <= tempo_clamped;
                tte_pkg::OP_COMMIT: begin
                    r_tick <= (tick_inc == i_cfg.ppq) ? '0 : tick_inc;
                    if (r_measure) begin
                        r_last_time <= r_now;
                        r_have_last <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            tte_pkg::OP_LATCH: begin
                r_now     <= i_timestamp_us;
                r_phase   <= r_tick;
                r_updated <= 1'b0;
            end
            tte_pkg::OP_MEASURE:  r_measure <= (div_rem == '0);
            tte_pkg::OP_SUM:      r_sum <= div_quo[tte_pkg::SUM_W-1:0]
                                         + tte_pkg::SUM_W'({r_smoothed, 2'b00});
            tte_pkg::OP_MUL:      r_prod <= tte_pkg::PROD_W'(r_sum)
                                          * tte_pkg::PROD_W'(tte_pkg::RECIP5);
            tte_pkg::OP_INTERVAL: r_updated <= 1'b1;
            tte_pkg::OP_DENOM:    r_denom <= tte_pkg::DENOM_W'(r_smoothed)
                                           * tte_pkg::DENOM_W'(i_cfg.ppq);
            tte_pkg::OP_OUT: begin
                r_out_int   <= r_smoothed;
                r_out_tempo <= r_tempo_val;
                r_out_upd   <= r_updated;
                r_out_phase <= r_phase;
            end
            default: ;
        endcase
    end

    assign o_status.div_done   = div_done;
    assign o_status.measure    = r_measure;
    assign o_status.have_last  = r_have_last;
    assign o_status.denom_zero = (r_denom == '0);
    assign o_status.out_free   = out_free;

    assign o_valid       = r_out_valid;
    assign o_interval_ms = r_out_int;
    assign o_tempo       = r_out_tempo;
    assign o_updated     = r_out_upd;
    assign o_tick_phase  = r_out_phase;

endmodule

// ===== src/tte_ctrl.sv =====
// Controller state machine sequencing one item through the datapath.
module tte_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  tte_pkg::t_status  i_status,
    output tte_pkg::t_op      o_op
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_MOD_WAIT,
        S_MOD_CHECK,
        S_BRANCH,
        S_EL,
        S_EL_WAIT,
        S_SUM,
        S_MUL,
        S_INTERVAL,
        S_DENOM,
        S_TDIV,
        S_TDIV_WAIT,
        S_TEMPO,
        S_COMMIT,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_op    = tte_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_op    = tte_pkg::OP_LATCH;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                o_op    = tte_pkg::OP_DIV_MOD;
                n_state = S_MOD_WAIT;
            end
            S_MOD_WAIT: begin
                if (i_status.div_done) begin
                    n_state = S_MOD_CHECK;
                end
            end
            S_MOD_CHECK: begin
                o_op    = tte_pkg::OP_MEASURE;
                n_state = S_BRANCH;
            end
            S_BRANCH: begin
                n_state = (i_status.measure && i_status.have_last) ? S_EL : S_COMMIT;
            end
            S_EL: begin
                o_op    = tte_pkg::OP_DIV_ELAPSED;
                n_state = S_EL_WAIT;
            end
            S_EL_WAIT: begin
                if (i_status.div_done) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                o_op    = tte_pkg::OP_SUM;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_op    = tte_pkg::OP_MUL;
                n_state = S_INTERVAL;
            end
            S_INTERVAL: begin
                o_op    = tte_pkg::OP_INTERVAL;
                n_state = S_DENOM;
            end
            S_DENOM: begin
                o_op    = tte_pkg::OP_DENOM;
                n_state = S_TDIV;
            end
            S_TDIV: begin
                if (i_status.denom_zero) begin
                    n_state = S_TEMPO;
                end else begin
                    o_op    = tte_pkg::OP_DIV_TEMPO;
                    n_state = S_TDIV_WAIT;
                end
            end
            S_TDIV_WAIT: begin
                if (i_status.div_done) begin
                    n_state = S_TEMPO;
                end
            end
            S_TEMPO: begin
                o_op    = tte_pkg::OP_TEMPO;
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_op    = tte_pkg::OP_COMMIT;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_op    = tte_pkg::OP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== src/tick_tempo_estimator_top.sv =====
// Top level of the tick tempo estimator: register file, controller and datapath.
//
//  channel   | handshake          | payload
//  ----------+--------------------+------------------------------------------------
//  tick in   | i_valid / o_ready  | i_timestamp_us[31:0]
//  result    | o_valid / i_ready  | o_interval_ms[15:0] o_tempo[23:0] o_updated
//            |                    | o_tick_phase[6:0]
//  config    | psel/penable/pready| paddr[4:0] pwrite pwdata[31:0] prdata[31:0]
//
//  Every tick runs the groove modulo (7 quotient bits) on the one-bit-per-cycle
//  divider; a measuring tick also runs the elapsed-time division (32 quotient
//  bits) and, unless its denominator is zero, the tempo division (24 quotient
//  bits). One item is in work at a time.
//  Reset (i_rst_n low at a clock edge) restores register defaults and clears
//  tick count, stored time, smoothed interval and tempo.
//  A stalled result holds in the output register; the block keeps working on
//  the next item and waits only when a second result is ready to go out.
module tick_tempo_estimator_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // tick input
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [tte_pkg::TS_W-1:0]       i_timestamp_us,
    // result output
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [tte_pkg::INT_W-1:0]      o_interval_ms,
    output logic [tte_pkg::TEMPO_W-1:0]    o_tempo,
    output logic                           o_updated,
    output logic [tte_pkg::PHASE_W-1:0]    o_tick_phase,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tte_pkg::PADDR_W-1:0]    paddr,
    input  logic [tte_pkg::PDATA_W-1:0]    pwdata,
    output logic [tte_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);

    tte_pkg::t_cfg    cfg;
    tte_pkg::t_op     op;
    tte_pkg::t_status status;

    // Hold configuration; writes must arrive only while no tick is in work, which the block itself does not enforce
    tte_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sequence each tick: modulo check, then for a measuring tick elapsed division, smoothing, tempo
    tte_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_op     (op)
    );

    // Compute and hold the result until the consumer takes it
    tte_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (op),
        .i_cfg          (cfg),
        .i_timestamp_us (i_timestamp_us),
        .i_ready        (i_ready),
        .o_status       (status),
        .o_valid        (o_valid),
        .o_interval_ms  (o_interval_ms),
        .o_tempo        (o_tempo),
        .o_updated      (o_updated),
        .o_tick_phase   (o_tick_phase)
    );

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench of the tick tempo estimator: directed, corner and random runs.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One result item as the block presents it on its output ports.
    typedef struct packed {
        logic [tte_pkg::INT_W-1:0]   interval_ms;
        logic [tte_pkg::TEMPO_W-1:0] tempo;
        logic                        updated;
        logic [tte_pkg::PHASE_W-1:0] tick_phase;
    } t_tick_result;

    // Block inputs: every one starts from a known value.
    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_valid        = 1'b0;
    logic [tte_pkg::TS_W-1:0]      i_timestamp_us = '0;
    logic                          i_ready        = 1'b0;
    logic                          psel           = 1'b0;
    logic                          penable        = 1'b0;
    logic                          pwrite         = 1'b0;
    logic [tte_pkg::PADDR_W-1:0]   paddr          = '0;
    logic [tte_pkg::PDATA_W-1:0]   pwdata         = '0;

    // Block outputs.
    logic                          o_ready;
    logic                          o_valid;
    logic [tte_pkg::INT_W-1:0]     o_interval_ms;
    logic [tte_pkg::TEMPO_W-1:0]   o_tempo;
    logic                          o_updated;
    logic [tte_pkg::PHASE_W-1:0]   o_tick_phase;
    logic [tte_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;

    // Estimator copy: configuration and state as the block should hold them.
    tte_pkg::t_cfg                 est_cfg;
    logic [tte_pkg::PPQ_W-1:0]     est_tick_count;
    logic [tte_pkg::TS_W-1:0]      est_last_ts;
    logic                          est_have_last;
    logic [tte_pkg::INT_W-1:0]     est_interval;
    logic [tte_pkg::TEMPO_W-1:0]   est_tempo;

    t_tick_result                  pending_results[$];
    int                            mismatch_count = 0;
    int                            result_count   = 0;
    bit                            idle_on        = 1'b1;
    int                            ready_hold     = 0;
    logic [tte_pkg::TS_W-1:0]      ts_now         = '0;

    tick_tempo_estimator_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_timestamp_us (i_timestamp_us),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_interval_ms  (o_interval_ms),
        .o_tempo        (o_tempo),
        .o_updated      (o_updated),
        .o_tick_phase   (o_tick_phase),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 i_clk = ~i_clk;

    // Hard stop in case a handshake never completes.
    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatch_count++;
        $display("[%0t] mismatch %s: got %0d expected %0d (result %0d)",
                 $realtime, what, got, want, result_count);
    endtask

    function automatic longint unsigned clamp_to(input longint unsigned x,
                                                 input longint unsigned lo,
                                                 input longint unsigned hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    // Advance the estimator copy by one tick and return the result it owes.
    function automatic t_tick_result predict_tick(input logic [tte_pkg::TS_W-1:0] ts);
        int unsigned                groove;
        logic [tte_pkg::TS_W-1:0]   elapsed;
        longint unsigned            raw;
        longint unsigned            avg;
        longint unsigned            denom;
        longint unsigned            tempo_raw;
        t_tick_result               res;
        // a zero groove divisor measures on every tick
        groove = (est_cfg.groove == '0) ? 32'd1 : 32'(est_cfg.groove);
        res.updated    = 1'b0;
        res.tick_phase = est_tick_count;
        if (est_tick_count % groove == 0) begin
            if (est_have_last) begin
                // elapsed time wraps modulo 2^32
                elapsed = ts - est_last_ts;
                raw = 64'(elapsed);
                raw = raw / (groove * 1000);
                avg = (raw + 4 * longint'(est_interval)) / 5;
                est_interval = tte_pkg::INT_W'(clamp_to(avg, 64'(est_cfg.min_int),
                                                        64'(est_cfg.max_int)));
                denom = 64'(est_interval);
                denom = denom * est_cfg.ppq;
                // zero divisor saturates before the tempo clamp
                tempo_raw = (denom == 0) ? 64'(tte_pkg::TEMPO_SAT)
                                         : 64'(tte_pkg::TEMPO_NUM) / denom;
                if (tempo_raw > tte_pkg::TEMPO_SAT) tempo_raw = 64'(tte_pkg::TEMPO_SAT);
                est_tempo = tte_pkg::TEMPO_W'(clamp_to(tempo_raw, 64'(est_cfg.min_tempo),
                                                       64'(est_cfg.max_tempo)));
                res.updated = 1'b1;
            end
            est_last_ts   = ts;
            est_have_last = 1'b1;
        end
        // wrap only on an exact match with the wrap point, else modulo 128
        est_tick_count = est_tick_count + 1'b1;
        if (est_tick_count == est_cfg.ppq) est_tick_count = '0;
        res.interval_ms = est_interval;
        res.tempo       = est_tempo;
        return res;
    endfunction

    // Receiver: take results, idle at random, or hold off for a counted stretch.
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= !(idle_on && $urandom_range(99) < 24);
        end
    end

    // Compare each accepted result with the oldest expected one.
    always @(posedge i_clk) begin
        t_tick_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no tick pending", 0, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_interval_ms !== want.interval_ms)
                    report_mismatch("interval_ms", 64'(o_interval_ms), 64'(want.interval_ms));
                if (o_tempo !== want.tempo)
                    report_mismatch("tempo", 64'(o_tempo), 64'(want.tempo));
                if (o_updated !== want.updated)
                    report_mismatch("updated", 64'(o_updated), 64'(want.updated));
                if (o_tick_phase !== want.tick_phase)
                    report_mismatch("tick_phase", 64'(o_tick_phase), 64'(want.tick_phase));
            end
            result_count++;
        end
    end

    // Offer one tick item; idle first at random, hold valid until accepted.
    task automatic send_tick(input logic [tte_pkg::TS_W-1:0] ts);
        if (idle_on && $urandom_range(99) < 24) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while (idle_on && $urandom_range(99) < 24);
        end
        i_valid        <= 1'b1;
        i_timestamp_us <= ts;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(predict_tick(ts));
    endtask

    // Drop valid and wait until every expected result has arrived.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Write one register, then read it back through the same select.
    task automatic write_register(input logic [tte_pkg::REG_W-1:0] idx,
                                  input logic [tte_pkg::PDATA_W-1:0] value);
        logic [tte_pkg::PDATA_W-1:0] readback;
        readback = '0;
        case (idx)
            tte_pkg::REG_GROOVE: begin
                est_cfg.groove = value[tte_pkg::GROOVE_W-1:0];
                readback[tte_pkg::GROOVE_W-1:0] = value[tte_pkg::GROOVE_W-1:0];
            end
            tte_pkg::REG_PPQ: begin
                est_cfg.ppq = value[tte_pkg::PPQ_W-1:0];
                readback[tte_pkg::PPQ_W-1:0] = value[tte_pkg::PPQ_W-1:0];
            end
            tte_pkg::REG_MIN_INT: begin
                est_cfg.min_int = value[tte_pkg::INT_W-1:0];
                readback[tte_pkg::INT_W-1:0] = value[tte_pkg::INT_W-1:0];
            end
            tte_pkg::REG_MAX_INT: begin
                est_cfg.max_int = value[tte_pkg::INT_W-1:0];
                readback[tte_pkg::INT_W-1:0] = value[tte_pkg::INT_W-1:0];
            end
            tte_pkg::REG_MIN_TEMPO: begin
                est_cfg.min_tempo = value[tte_pkg::TEMPO_W-1:0];
                readback[tte_pkg::TEMPO_W-1:0] = value[tte_pkg::TEMPO_W-1:0];
            end
            tte_pkg::REG_MAX_TEMPO: begin
                est_cfg.max_tempo = value[tte_pkg::TEMPO_W-1:0];
                readback[tte_pkg::TEMPO_W-1:0] = value[tte_pkg::TEMPO_W-1:0];
            end
            default: ;
        endcase
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        // write lands at this edge; turn straight into a read setup
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== readback) report_mismatch("register readback", 64'(prdata), 64'(readback));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic [tte_pkg::PDATA_W-1:0] groove,
                              input logic [tte_pkg::PDATA_W-1:0] ppq,
                              input logic [tte_pkg::PDATA_W-1:0] min_int,
                              input logic [tte_pkg::PDATA_W-1:0] max_int,
                              input logic [tte_pkg::PDATA_W-1:0] min_tempo,
                              input logic [tte_pkg::PDATA_W-1:0] max_tempo);
        wait_for_results();
        write_register(tte_pkg::REG_GROOVE, groove);
        write_register(tte_pkg::REG_PPQ, ppq);
        write_register(tte_pkg::REG_MIN_INT, min_int);
        write_register(tte_pkg::REG_MAX_INT, max_int);
        write_register(tte_pkg::REG_MIN_TEMPO, min_tempo);
        write_register(tte_pkg::REG_MAX_TEMPO, max_tempo);
    endtask

    // Send a run of ticks at a steady tempo with jitter; some ticks jump to random times.
    task automatic send_paced(input int count, input int ms_lo, input int ms_hi,
                              input int noise_pct);
        int unsigned ms;
        ms = $urandom_range(ms_hi, ms_lo);
        repeat (count) begin
            if ($urandom_range(99) < noise_pct) begin
                ts_now = $urandom;
            end else begin
                if ($urandom_range(99) < 10) ms = $urandom_range(ms_hi, ms_lo);
                ts_now = ts_now + ms * 1000 + $urandom_range(999);
            end
            send_tick(ts_now);
        end
    endtask

    // Reset defaults: timestamp extremes, first measurement latch, and a run across the wrap.
    task automatic test_directed_defaults();
        send_tick(32'h0000_0000);
        send_tick(32'hFFFF_FFFF);
        ts_now = 32'hFFFD_0000;
        send_paced(22, 20, 20, 0);
    endtask

    // Register corners: zero groove and wrap point, inverted clamps, extremes of every field.
    task automatic test_config_corners();
        // zero groove and zero wrap point: every tick measures, tempo saturates
        set_config(0, 0, 0, 16'hFFFF, 0, 24'hFFFFFF);
        send_paced(40, 0, 3, 10);
        // lower limits above upper limits: values under the lower limit take it, others the upper one
        set_config(31, 127, 16'hFFFF, 1, 24'hFFFFFF, 0);
        send_paced(40, 1, 100, 10);
        // one tick per quarter, widest limits, plenty of random times
        set_config(1, 1, 1, 16'hFFFF, 0, 24'hFFFFFF);
        send_paced(40, 1, 2000, 40);
        set_config(24, 96, 1, 16'hFFFF, 0, 24'hFFFFFF);
        send_paced(40, 1, 50, 5);
        // shrink the wrap point under the current count: counter runs on to 127
        set_config(2, 3, 2, 300, 256, 24'h0F0000);
        send_paced(60, 1, 50, 5);
    endtask

    // Random phases: mostly sane tempo settings, sometimes raw 32-bit register writes.
    task automatic test_random_tempo();
        repeat (12) begin
            if ($urandom_range(99) < 30) begin
                set_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else begin
                set_config($urandom_range(24, 1), $urandom_range(96, 1), $urandom_range(20, 0),
                           $urandom_range(300, 20), $urandom_range(30 * 256, 0),
                           $urandom_range(24'hFFFFFF, 200 * 256));
            end
            send_paced(45, 1, $urandom_range(200, 2), 8);
        end
    endtask

    // Hold the receiver off long enough for the block to fill and stall its input.
    task automatic test_output_backpressure();
        set_config(3, 24, 5, 125, 5120, 76800);
        ready_hold = 400;
        send_paced(30, 5, 60, 5);
    endtask

    // Long stretch with neither side idling.
    task automatic test_back_to_back();
        idle_on = 1'b0;
        send_paced(40, 5, 60, 5);
        idle_on = 1'b1;
    endtask

    initial begin
        est_cfg.groove    = tte_pkg::RST_GROOVE;
        est_cfg.ppq       = tte_pkg::RST_PPQ;
        est_cfg.min_int   = tte_pkg::RST_MIN_INT;
        est_cfg.max_int   = tte_pkg::RST_MAX_INT;
        est_cfg.min_tempo = tte_pkg::RST_MIN_TEMPO;
        est_cfg.max_tempo = tte_pkg::RST_MAX_TEMPO;
        est_tick_count    = '0;
        est_last_ts       = '0;
        est_have_last     = 1'b0;
        est_interval      = '0;
        est_tempo         = '0;

        // hold reset, then release it for good
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_defaults();
        test_config_corners();
        test_random_tempo();
        test_output_backpressure();
        test_back_to_back();

        // drain, then wait a while longer so that stray results show up
        wait_for_results();
        repeat (120) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
